@@ sv/fifo_queue_with_reverse_macros.svh @@
// Assertion macros shared by the queue checker.
`ifndef FIFO_QUEUE_WITH_REVERSE_MACROS_SVH
`define FIFO_QUEUE_WITH_REVERSE_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define FQR_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that cons holds in the same cycle as ante.
`define FQR_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ sv/fqr_pkg.sv @@
// Package with the command, status and transaction types of the queue.
`timescale 1ns / 1ps
`default_nettype none
package fqr_pkg;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_REV = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  localparam logic signed [31:0] NEG_ONE = -32'sd1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
    logic [7:0]         entry_count;
    logic signed [31:0] last_removed;
  } out_t;

endpackage
`default_nettype wire

@@ sv/fifo_queue_with_reverse.sv @@
// Top level of the bounded FIFO with an in-place reverse command.
`timescale 1ns / 1ps
`default_nettype none
// Bounded FIFO of signed 32-bit values over a ring buffer of DEPTH entries in one
// synchronous memory. A transaction is taken when start is high and busy is low;
// each one yields exactly one result, shown for a single cycle with out_valid
// high, and the receiver cannot stall it. Enqueue, reverse, an empty dequeue and
// an unused code report on the cycle after acceptance; busy stays low, so they
// may come back to back. A dequeue that finds data waits on the registered memory
// read: rd_data_r captures the head entry at acceptance, busy is high in ST_POP,
// and the result is registered from rd_data_r there. Reverse moves no data: it
// flips a direction flag and moves the head pointer to the other end. entry_count
// reports the held count modulo 256.
module fifo_queue_with_reverse #(
  parameter int DEPTH = 128
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output      logic         busy,
  input  wire fqr_pkg::in_t in_data,
  output      logic         out_valid,
  output      fqr_pkg::out_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  fqr_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               rev_r, rev_nxt;
  logic signed [31:0] last_r, last_nxt;
  logic [CW-1:0]      pend_count_r, pend_count_nxt;
  logic               out_valid_r, out_valid_nxt;
  fqr_pkg::out_t      out_r, out_nxt;

  logic               accept;
  logic               we;
  logic [AW-1:0]      enq_slot, deq_slot, rev_slot;
  logic signed [31:0] rd_data_r;
  logic signed [31:0] mem [DEPTH];

  // Physical slot at logical distance d from the front.
  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] head, input logic rev,
                                           input logic [CW-1:0] d);
    logic [SW-1:0] s;
    if (!rev) begin
      s = SW'(head) + SW'(d);
      if (s >= SW'(DEPTH)) begin
        s = s - SW'(DEPTH);
      end
    end else if (SW'(head) >= SW'(d)) begin
      s = SW'(head) - SW'(d);
    end else begin
      s = SW'(head) + SW'(DEPTH) - SW'(d);
    end
    return AW'(s);
  endfunction

  assign busy     = (state_r == fqr_pkg::ST_POP);
  assign accept   = start && !busy;
  assign enq_slot = slot_f(head_r, rev_r, count_r);
  assign deq_slot = slot_f(head_r, rev_r, CW'(1));
  assign rev_slot = slot_f(head_r, rev_r, count_r - CW'(1));

  // Entry store: write on enqueue, read the head slot every cycle. A dequeue
  // samples the read at its own acceptance edge, after any earlier enqueue
  // write has landed, so no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[enq_slot] <= in_data.push_value;
    end
    rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqr_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      last_r      <= fqr_pkg::NEG_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    out_r        <= out_nxt;
    pend_count_r <= pend_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    rev_nxt        = rev_r;
    last_nxt       = last_r;
    pend_count_nxt = pend_count_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    we             = 1'b0;

    unique case (state_r)
      fqr_pkg::ST_IDLE: begin
        if (accept) begin
          // Default response: ok, no data, state unchanged.
          out_valid_nxt        = 1'b1;
          out_nxt.status       = fqr_pkg::STS_OK;
          out_nxt.pop_value    = fqr_pkg::NEG_ONE;
          out_nxt.entry_count  = 8'(count_r);
          out_nxt.last_removed = last_r;
          unique case (in_data.cmd)
            fqr_pkg::CMD_ENQ: begin
              if (count_r >= CW'(DEPTH)) begin
                out_nxt.status = fqr_pkg::STS_FULL;
              end else begin
                we                  = 1'b1;
                count_nxt           = count_r + CW'(1);
                out_nxt.entry_count = 8'(count_nxt);
              end
            end
            fqr_pkg::CMD_DEQ: begin
              if (count_r == '0) begin
                out_nxt.status = fqr_pkg::STS_EMPTY;
              end else begin
                // Hold the response until the head entry comes out of memory.
                out_valid_nxt  = 1'b0;
                head_nxt       = deq_slot;
                count_nxt      = count_r - CW'(1);
                pend_count_nxt = count_nxt;
                state_nxt      = fqr_pkg::ST_POP;
              end
            end
            fqr_pkg::CMD_REV: begin
              if (count_r == '0) begin
                out_nxt.status = fqr_pkg::STS_EMPTY;
              end else begin
                head_nxt = rev_slot;
                rev_nxt  = !rev_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      fqr_pkg::ST_POP: begin
        // Deliver the dequeued entry and record it as last removed.
        out_valid_nxt        = 1'b1;
        out_nxt.status       = fqr_pkg::STS_OK;
        out_nxt.pop_value    = rd_data_r;
        out_nxt.entry_count  = 8'(pend_count_r);
        out_nxt.last_removed = rd_data_r;
        last_nxt             = rd_data_r;
        state_nxt            = fqr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fqr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ sv/fqr_checker.sv @@
// Port-level checker for the queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_queue_with_reverse_macros.svh"
module fqr_checker #(
  parameter int DEPTH = 128
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire fqr_pkg::out_t out_data
);

  // Busy covers exactly the read cycle of one dequeue.
  `FQR_NEXT(a_busy_one_cycle, busy, !busy, "busy held longer than one cycle")
  `FQR_NEXT(a_busy_then_pop, busy,
            out_valid && out_data.status == fqr_pkg::STS_OK
            && out_data.pop_value == out_data.last_removed,
            "dequeue result missing after busy")
  `FQR_NEXT(a_accept_answered, start && !busy, out_valid || busy,
            "accepted transaction got no result or pending read")
  `FQR_SAME(a_full_count, out_valid && out_data.status == fqr_pkg::STS_FULL,
            out_data.entry_count == 8'(DEPTH) && out_data.pop_value == fqr_pkg::NEG_ONE,
            "full result with wrong count or data")
  `FQR_SAME(a_empty_count, out_valid && out_data.status == fqr_pkg::STS_EMPTY,
            out_data.entry_count == 8'd0 && out_data.pop_value == fqr_pkg::NEG_ONE,
            "empty result with wrong count or data")

endmodule

bind fifo_queue_with_reverse fqr_checker #(.DEPTH(DEPTH)) u_fqr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_data (out_data)
);
`default_nettype wire

@@ bench/queue_result_checker.sv @@
// Checker that predicts and compares every result of the reversible FIFO.
`timescale 1ns / 1ps
module queue_result_checker #(
  parameter int DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  fqr_pkg::in_t   in_data,
  input  logic           out_valid,
  input  fqr_pkg::out_t  out_data,
  output int             mismatches,
  output int             pending
);

  // Shadow copy of the ring buffer.
  logic signed [31:0] shadow_store [DEPTH];
  int                 shadow_head;
  int                 shadow_count;
  bit                 shadow_flipped;
  logic signed [31:0] shadow_last;

  fqr_pkg::out_t awaited_results [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Physical slot at logical distance k from the front.
  function automatic int slot_of(int k);
    if (shadow_flipped) return (shadow_head + DEPTH - (k % DEPTH)) % DEPTH;
    return (shadow_head + k) % DEPTH;
  endfunction

  function automatic fqr_pkg::out_t predict_queue_step(fqr_pkg::in_t txn);
    fqr_pkg::out_t r;
    r.status    = fqr_pkg::STS_OK;
    r.pop_value = fqr_pkg::NEG_ONE;
    case (txn.cmd)
      fqr_pkg::CMD_ENQ: begin
        if (shadow_count >= DEPTH) begin
          r.status = fqr_pkg::STS_FULL;
        end else begin
          shadow_store[slot_of(shadow_count)] = txn.push_value;
          shadow_count++;
        end
      end
      fqr_pkg::CMD_DEQ: begin
        if (shadow_count == 0) begin
          r.status = fqr_pkg::STS_EMPTY;
        end else begin
          r.pop_value  = shadow_store[shadow_head];
          shadow_last  = r.pop_value;
          shadow_head  = slot_of(1);
          shadow_count--;
        end
      end
      fqr_pkg::CMD_REV: begin
        if (shadow_count == 0) begin
          r.status = fqr_pkg::STS_EMPTY;
        end else begin
          shadow_head    = slot_of(shadow_count - 1);
          shadow_flipped = !shadow_flipped;
        end
      end
      default: ;  // unused code: nothing changes
    endcase
    r.entry_count  = 8'(shadow_count);
    r.last_removed = shadow_last;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%08h, want 0x%08h", field, got, want));
  endtask

  always @(posedge clk) begin
    fqr_pkg::out_t want;
    if (!rst_n) begin
      awaited_results.delete();
      shadow_head    = 0;
      shadow_count   = 0;
      shadow_flipped = 1'b0;
      shadow_last    = fqr_pkg::NEG_ONE;
      pending       <= 0;
    end else begin
      // Results issued before this edge always belong to older transactions.
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", 32'(out_data.status), 32'(want.status));
          compare_field("pop_value", out_data.pop_value, want.pop_value);
          compare_field("entry_count", 32'(out_data.entry_count), 32'(want.entry_count));
          compare_field("last_removed", out_data.last_removed, want.last_removed);
        end
      end
      if (start && !busy) awaited_results.push_back(predict_queue_step(in_data));
      pending <= awaited_results.size();
    end
  end

endmodule

@@ bench/tb_fifo_queue_with_reverse.sv @@
// Testbench top: drives commands into the reversible FIFO and gives the verdict.
`timescale 1ns / 1ps
module tb_fifo_queue_with_reverse;

  localparam int DEPTH          = 128;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int TAIL_CYCLES    = 4;
  localparam int PHASE_ITEMS    = 215;

  // The block ignores this code; keep it in the mix to check that.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  // Traffic mixes of the random part.
  typedef enum int {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } mix_t;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          start     = 1'b0;
  fqr_pkg::in_t  in_data   = '0;
  logic          busy;
  logic          out_valid;
  fqr_pkg::out_t out_data;

  int mismatches;
  int pending;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fifo_queue_with_reverse #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  queue_result_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Hold one transaction on the input until the block takes it, then
  // optionally drop start for a short random gap. Leave start high when
  // no gap follows so the next call does not touch it twice in one step.
  task automatic issue_cmd(input logic [1:0] code, input logic signed [31:0] value,
                           input int idle_pct);
    in_data <= '{cmd: code, push_value: value};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      // Scramble the idle payload; the block must not look at it.
      in_data <= fqr_pkg::in_t'({2'($urandom_range(3)), 32'($urandom())});
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly random values, with the signed extremes mixed in.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return -32'sd1;
      default: return 32'($urandom());
    endcase
  endfunction

  // Choose a command code with a bias that walks the fill level up,
  // down or around the middle.
  function automatic logic [1:0] pick_code(mix_t mix);
    int roll;
    int enq_lim;
    int deq_lim;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:     begin enq_lim = 85; deq_lim = 93; end
      MIX_DRAIN:    begin enq_lim = 10; deq_lim = 88; end
      default:      begin enq_lim = 45; deq_lim = 85; end
    endcase
    if (roll < enq_lim) return fqr_pkg::CMD_ENQ;
    if (roll < deq_lim) return fqr_pkg::CMD_DEQ;
    if (roll < 98)      return fqr_pkg::CMD_REV;
    return CMD_UNUSED;
  endfunction

  initial begin
    int idle_pct;
    mix_t mix;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty-queue corners, the ignored code, a single-entry
    // reverse and the signed extremes flowing through a reversed queue.
    issue_cmd(fqr_pkg::CMD_DEQ, VAL_MAX, 0);       // dequeue when empty
    issue_cmd(fqr_pkg::CMD_REV, 32'sd0, 0);        // reverse when empty
    issue_cmd(CMD_UNUSED, -32'sd1, 0);             // ignored code
    issue_cmd(fqr_pkg::CMD_ENQ, VAL_MIN, 0);
    issue_cmd(fqr_pkg::CMD_REV, 32'sd0, 0);        // reverse of a single entry
    issue_cmd(fqr_pkg::CMD_DEQ, 32'sd0, 0);
    issue_cmd(fqr_pkg::CMD_DEQ, 32'sd0, 0);        // empty again, last value kept
    issue_cmd(fqr_pkg::CMD_ENQ, VAL_MAX, 0);
    issue_cmd(fqr_pkg::CMD_ENQ, 32'sd0, 0);
    issue_cmd(fqr_pkg::CMD_ENQ, -32'sd1, 0);
    issue_cmd(fqr_pkg::CMD_ENQ, 32'sh5555_5555, 0);
    issue_cmd(fqr_pkg::CMD_ENQ, 32'shaaaa_aaaa, 0);
    issue_cmd(fqr_pkg::CMD_REV, 32'sd0, 0);
    issue_cmd(fqr_pkg::CMD_DEQ, 32'sd0, 0);
    issue_cmd(fqr_pkg::CMD_ENQ, 32'sd1, 0);        // append while reversed
    issue_cmd(fqr_pkg::CMD_REV, 32'sd0, 0);
    issue_cmd(fqr_pkg::CMD_DEQ, 32'sd0, 0);
    issue_cmd(fqr_pkg::CMD_DEQ, 32'sd0, 0);
    issue_cmd(CMD_UNUSED, VAL_MIN, 0);
    issue_cmd(fqr_pkg::CMD_REV, 32'sd0, 0);
    issue_cmd(fqr_pkg::CMD_DEQ, 32'sd0, 0);
    issue_cmd(fqr_pkg::CMD_DEQ, 32'sd0, 0);
    issue_cmd(fqr_pkg::CMD_DEQ, 32'sd0, 0);

    // Pause with the queue quiet before the random traffic starts.
    drain_results();

    // Random part: fill, balanced and drain mixes, first without gaps,
    // then with heavy and light sender gaps. Fill phases run long enough
    // to sit at full; drain phases run long enough to hit empty.
    for (int phase = 0; phase < 9; phase++) begin
      mix = mix_t'(phase % 3);
      case (phase / 3)
        0:       idle_pct = 0;
        1:       idle_pct = 58;
        default: idle_pct = 16;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++)
        issue_cmd(pick_code(mix), pick_value(), idle_pct);
      if (phase % 4 == 3) drain_results();
    end

    // Drain, let the pipeline settle, then judge.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/fqr_pkg.sv
sv/fifo_queue_with_reverse.sv
sv/fqr_checker.sv
bench/queue_result_checker.sv
bench/tb_fifo_queue_with_reverse.sv
